// ===== design/intel_hex_record_parser_assert.svh =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser_assert.svh
// assertion macros used by the hex parser core (ihex_core)
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define IHEX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// types and constants of the intel hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } ihex_kind_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_COLON  = 3'd1,
    STS_NONHEX    = 3'd2,
    STS_ODD       = 3'd3,
    STS_CHECKSUM  = 3'd4,
    STS_SIZE      = 3'd5,
    STS_EXT_LEN   = 3'd6,
    STS_TYPE      = 3'd7
  } ihex_status_e;

  localparam logic [7:0] COLON_CHAR   = 8'h3A;
  localparam logic [8:0] HEADER_BYTES = 9'd4;
  localparam logic [8:0] FRAME_BYTES  = 9'd5;
  localparam logic [8:0] INDEX_MAX    = 9'd511;
  localparam logic [7:0] EXT_LEN      = 8'd2;

  // record types
  localparam logic [7:0] REC_DATA      = 8'd0;
  localparam logic [7:0] REC_EOF       = 8'd1;
  localparam logic [7:0] REC_EXT_SEG   = 8'd2;
  localparam logic [7:0] REC_EXT_LIN   = 8'd4;
  localparam logic [7:0] REC_START_LIN = 8'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } ihex_in_t;

  typedef struct packed {
    ihex_kind_e   result_kind;
    logic [31:0]  byte_address;
    logic [7:0]   data_byte;
    logic [7:0]   record_type;
    ihex_status_e status;
  } ihex_out_t;

endpackage

// ===== design/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// intel hex text parser, one character per request
// ----------------------------------------------------------------------------
// Takes one character per cycle with no bubbles as long as the result side
// keeps up; each character gives zero or one result. A character passes an
// input register, then the record state update and result decode, and lands
// in the result register, which drives the output. The result register alone
// sets the rate: an output stall holds the input once the input register is
// also full. After an EOF record or any error the parser halts and silently
// drops all further characters until reset.
module intel_hex_record_parser import ihex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ihex_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ihex_out_t out_item_o
);

  logic      in_vld_q;
  ihex_in_t  in_q;
  logic      adv;
  logic      step;
  logic      res_vld;
  ihex_out_t res;

  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  ihex_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ihex_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/ihex_core.sv =====
// ----------------------------------------------------------------------------
// ihex_core
// record state and per-character decode, at most one result per character
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_assert.svh"

module ihex_core import ihex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  ihex_in_t  item_i,
  output logic      res_vld_o,
  output ihex_out_t res_o
);

  logic        in_rec_q, in_rec_d;
  logic [3:0]  hn_q, hn_d;
  logic        np_q, np_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cs_q, cs_d;
  logic [15:0] ext_q, ext_d;
  logic [31:0] off_q, off_d;
  logic        halted_q, halted_d;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic [7:0] byte_val;
  logic       fin;

  // uppercase hex digit decode
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = 4'd0;
    if (item_i.char_code >= 8'h30 && item_i.char_code <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = 4'(item_i.char_code - 8'h30);
    end else if (item_i.char_code >= 8'h41 && item_i.char_code <= 8'h46) begin
      hex_ok  = 1'b1;
      hex_val = 4'(item_i.char_code - 8'h37);
    end
  end

  assign byte_val = {hn_q, hex_val};

  always_comb begin
    in_rec_d  = in_rec_q;
    hn_d      = hn_q;
    np_d      = np_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    type_d    = type_q;
    cs_d      = cs_q;
    ext_d     = ext_q;
    off_d     = off_q;
    halted_d  = halted_q;
    fin       = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;

    if (step_i && !halted_q) begin
      if (!in_rec_q) begin
        if (item_i.char_code != COLON_CHAR) begin
          res_vld_o         = 1'b1;
          res_o.result_kind = KIND_ERROR;
          res_o.status      = STS_NO_COLON;
          halted_d          = 1'b1;
        end else begin
          in_rec_d = 1'b1;
          hn_d     = '0;
          np_d     = 1'b0;
          idx_d    = '0;
          cnt_d    = '0;
          addr_d   = '0;
          type_d   = '0;
          cs_d     = '0;
          ext_d    = '0;
          fin      = item_i.end_of_line;
        end
      end else if (!hex_ok) begin
        res_vld_o         = 1'b1;
        res_o.result_kind = KIND_ERROR;
        res_o.status      = STS_NONHEX;
        halted_d          = 1'b1;
      end else begin
        if (!np_q) begin
          hn_d = hex_val;
          np_d = 1'b1;
        end else begin
          np_d = 1'b0;
          cs_d = cs_q + byte_val;
          priority if (idx_q == 9'd0) begin
            cnt_d = byte_val;
          end else if (idx_q == 9'd1) begin
            addr_d[15:8] = byte_val;
          end else if (idx_q == 9'd2) begin
            addr_d[7:0] = byte_val;
          end else if (idx_q == 9'd3) begin
            type_d = byte_val;
          end else if (idx_q < HEADER_BYTES + {1'b0, cnt_q}) begin
            ext_d = {ext_q[7:0], byte_val};
            // data bytes go out before the line is checked
            if (type_q == REC_DATA && !item_i.end_of_line) begin
              res_vld_o          = 1'b1;
              res_o.result_kind  = KIND_DATA;
              res_o.byte_address = off_q + {16'd0, addr_q}
                                   + {23'd0, idx_q - HEADER_BYTES};
              res_o.data_byte    = byte_val;
              res_o.status       = STS_OK;
            end
          end else begin
            // checksum byte and anything past it only feed the sum
          end
          idx_d = (idx_q == INDEX_MAX) ? idx_q : idx_q + 9'd1;
        end
        fin = item_i.end_of_line;
      end

      // end of line checks, on the updated line state
      if (fin) begin
        in_rec_d           = 1'b0;
        res_vld_o          = 1'b1;
        res_o.byte_address = '0;
        res_o.data_byte    = '0;
        res_o.result_kind  = KIND_ERROR;
        halted_d           = 1'b1;
        priority if (np_d) begin
          res_o.status = STS_ODD;
        end else if (cs_d != 8'd0) begin
          res_o.status = STS_CHECKSUM;
        end else if (idx_d != FRAME_BYTES + {1'b0, cnt_d}) begin
          res_o.status = STS_SIZE;
        end else if ((type_d == REC_EXT_SEG || type_d == REC_EXT_LIN)
                     && cnt_d != EXT_LEN) begin
          res_o.status = STS_EXT_LEN;
        end else if (type_d == REC_DATA || type_d == REC_START_LIN
                     || type_d == REC_EOF) begin
          res_o.result_kind = KIND_ACCEPT;
          res_o.status      = STS_OK;
          halted_d          = (type_d == REC_EOF);
        end else if (type_d == REC_EXT_SEG) begin
          res_o.result_kind = KIND_ACCEPT;
          res_o.status      = STS_OK;
          halted_d          = 1'b0;
          off_d             = {12'd0, ext_d, 4'd0};
        end else if (type_d == REC_EXT_LIN) begin
          res_o.result_kind = KIND_ACCEPT;
          res_o.status      = STS_OK;
          halted_d          = 1'b0;
          off_d             = {ext_d, 16'd0};
        end else begin
          res_o.status = STS_TYPE;
        end
      end
      res_o.record_type = type_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec_q <= 1'b0;
      hn_q     <= '0;
      np_q     <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
      addr_q   <= '0;
      type_q   <= '0;
      cs_q     <= '0;
      ext_q    <= '0;
      off_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      in_rec_q <= in_rec_d;
      hn_q     <= hn_d;
      np_q     <= np_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      addr_q   <= addr_d;
      type_q   <= type_d;
      cs_q     <= cs_d;
      ext_q    <= ext_d;
      off_q    <= off_d;
      halted_q <= halted_d;
    end
  end

  `IHEX_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "parser left the halted state")
  `IHEX_ASSERT_NEXT(a_error_halts, res_vld_o && res_o.result_kind == KIND_ERROR,
                    halted_q, "error result without halt")
  `IHEX_ASSERT_NOW(a_data_in_record, res_vld_o && res_o.result_kind == KIND_DATA,
                   in_rec_q && !halted_q && idx_q >= HEADER_BYTES,
                   "data byte outside a record body")
  `IHEX_ASSERT_NOW(a_status_kind, res_vld_o && res_o.status != STS_OK,
                   res_o.result_kind == KIND_ERROR, "error status on a non-error result")

endmodule

// ===== design/ihex_out_reg.sv =====
// ----------------------------------------------------------------------------
// ihex_out_reg
// result register with valid/stall toward the consumer
// ----------------------------------------------------------------------------
module ihex_out_reg import ihex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_vld_i,
  input  ihex_out_t res_i,
  output logic      adv_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ihex_out_t out_item_o
);

  logic      vld_q;
  ihex_out_t data_q;

  // register can take a new result when empty or being drained
  assign adv_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = data_q;

endmodule
